@@ rtl/ubt_pkg.sv @@
// ----------------------------------------------------------------------------
// ubt_pkg: shared types and constants of the unordered bag table
// Operation codes, result bundle and default sizes.
// ----------------------------------------------------------------------------
package ubt_pkg;

    localparam int DEPTH_DEF = 16;   // number of entries
    localparam int WIDTH_DEF = 32;   // significant value bits
    localparam int VALUE_W   = 32;   // width of the value field on the port
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 5;    // width of the count field of a result

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic               rejected;
        logic               empty_res;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

@@ rtl/unordered_bag_table_unit.sv @@
// ----------------------------------------------------------------------------
// unordered_bag_table_unit: unsorted bag of values with compaction
// Insert appends, remove deletes the first match and closes the gap,
// contains searches, clear empties the table. One result per request.
//
//   channel | dir | tdata                  | tuser
//   --------+-----+------------------------+-----------
//   s_      | in  | [31:0] value           | [1:0] op
//   m_      | out | [0] found, [1] rejected| -
//           |     | [2] empty_res,[7:3] cnt|
//
// Steps: insert and clear go straight from the request to the result; contains
// and remove read and compare entries in turn up to the first match or the end,
// and a remove then moves each later entry down with a read and a write. This is
// set by the single read port of the entry memory and the one shared comparator.
// Reset: synchronous, active low; the table is empty afterwards.
// Stalls: a held result sits in the output register while the next request
// is accepted and worked on; the sequencer waits only to hand over a result.
// ----------------------------------------------------------------------------
module unordered_bag_table_unit import ubt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] value
    input  logic [1:0]   s_tuser,   // [1:0] op
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata    // [0] found, [1] rejected, [2] empty_res, [7:3] count
);

    // only the low WIDTH bits of a value take part, never more than the port
    localparam int DW = (WIDTH < VALUE_W) ? WIDTH : VALUE_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    res_t          res;
    logic          res_ready;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg,  m_tdata_next;

    ubt_ctrl #(
        .DEPTH (DEPTH),
        .DW    (DW),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (op_t'(s_tuser)),
        .req_value (s_tdata[DW-1:0]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_ready (res_ready)
    );

    ubt_mem #(
        .DEPTH (DEPTH),
        .DW    (DW),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = res.valid;
            if (res.valid) begin
                m_tdata_next = {res.count, res.empty_res, res.rejected, res.found};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/ubt_mem.sv @@
// ----------------------------------------------------------------------------
// ubt_mem: entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ubt_mem import ubt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int DW    = WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ubt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ubt_ctrl: operation sequencer
// Walks the stored entries through one shared equality comparator and
// compacts the table after a remove, one entry per read/write pair.
// ----------------------------------------------------------------------------
module ubt_ctrl import ubt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int DW    = WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request side
    input  logic          req_valid,
    output logic          req_ready,
    input  op_t           req_op,
    input  logic [DW-1:0] req_value,
    // entry storage
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [DW-1:0] mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [DW-1:0] mem_rdata,
    // result side
    output res_t          res,
    input  logic          res_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRD,    // read entry idx for compare
        ST_SCMP,   // compare entry with the request value
        ST_SHRD,   // read entry idx+1 for compaction
        ST_SHWR,   // write it back at idx
        ST_FIN     // result waits for the output register
    } state_t;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    state_t        state_reg, state_next;
    op_t           op_reg,    op_next;
    logic [DW-1:0] val_reg,   val_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [AW-1:0] idx_reg,   idx_next;
    logic          found_reg, found_next;
    logic          rej_reg,   rej_next;

    logic [AW-1:0] idx_inc;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_p2;
    logic          hit;

    assign idx_inc = idx_reg + AW'(1);
    assign idx_p1  = CW'(idx_reg) + CW'(1);
    assign idx_p2  = CW'(idx_reg) + CW'(2);
    // the shared compare unit
    assign hit     = (mem_rdata == val_reg);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        rej_next   = rej_reg;
        req_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next    = req_op;
                    val_next   = req_value;
                    idx_next   = '0;
                    found_next = 1'b0;
                    rej_next   = 1'b0;
                    unique case (req_op)
                        OP_INSERT: begin
                            if (cnt_reg == DEPTH_C) begin
                                rej_next = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_reg[AW-1:0];
                                mem_wdata = req_value;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                            state_next = ST_FIN;
                        end
                        OP_CLEAR: begin
                            cnt_next   = '0;
                            state_next = ST_FIN;
                        end
                        OP_REMOVE, OP_CONTAINS: begin
                            state_next = (cnt_reg == '0) ? ST_FIN : ST_SRD;
                        end
                    endcase
                end
            end
            ST_SRD: begin
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                if (hit) begin
                    found_next = 1'b1;
                    if (op_reg != OP_REMOVE) begin
                        state_next = ST_FIN;
                    end else if (idx_p1 == cnt_reg) begin
                        // match on the last entry: nothing to move
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_SHRD;
                    end
                end else if (idx_p1 == cnt_reg) begin
                    state_next = ST_FIN;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_SRD;
                end
            end
            ST_SHRD: begin
                mem_raddr  = idx_inc;
                state_next = ST_SHWR;
            end
            ST_SHWR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if (idx_p2 == cnt_reg) begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_FIN;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_SHRD;
                end
            end
            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            rej_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            rej_reg   <= rej_next;
        end
        op_reg  <= op_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
    end

    always_comb begin
        res.valid     = (state_reg == ST_FIN);
        res.found     = found_reg;
        res.rejected  = rej_reg;
        res.empty_res = (cnt_reg == '0);
        res.count     = COUNT_W'(cnt_reg);
    end

    // fill count never passes capacity
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_C)
        else $error("fill count above capacity");

    // a rejected insert only happens on a full table
    a_rej_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && rej_reg) |-> (cnt_reg == DEPTH_C && !found_reg))
        else $error("reject without full table");

    // compaction writes stay inside the occupied range
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHWR) |-> (idx_p1 < cnt_reg))
        else $error("compaction beyond last entry");

    // a remove that hits may only keep the count or drop it by one
    a_remove_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCMP && hit && op_reg == OP_REMOVE) |=>
        (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("remove changed count wrongly");

endmodule
